>>> rtl/core/hps_pkg.sv
package hps_pkg;

  // Configuration port geometry
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  // Register indexes (byte address is four times the index)
  localparam logic [IDX_W-1:0] REG_TIMEOUT     = 3'd0;
  localparam logic [IDX_W-1:0] REG_UNDERVOLT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_RATIO_SCALE = 3'd2;
  localparam logic [IDX_W-1:0] REG_DONE_RATIO  = 3'd3;
  localparam logic [IDX_W-1:0] REG_HOLD_RATIO  = 3'd4;

  localparam int TICK_W  = 16;
  localparam int UV_W    = 20;
  localparam int RATIO_W = 8;

  localparam logic [TICK_W-1:0]  RST_TIMEOUT     = 16'd100;
  localparam logic [UV_W-1:0]    RST_UNDERVOLT   = 20'd80000;
  localparam logic [RATIO_W-1:0] RST_RATIO_SCALE = 8'd100;
  localparam logic [RATIO_W-1:0] RST_DONE_RATIO  = 8'd90;
  localparam logic [RATIO_W-1:0] RST_HOLD_RATIO  = 8'd80;

  // Reported phase codes
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_INIT = 2'd1;
  localparam logic [1:0] PH_PRE  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // Fault mask bit positions
  localparam int FAULT_W        = 7;
  localparam int FB_PRE_SENSE_TO = 0;
  localparam int FB_MOT_SENSE_TO = 1;
  localparam int FB_UNDERVOLT    = 2;
  localparam int FB_MOT_MISMATCH = 3;
  localparam int FB_PRE_MISMATCH = 4;
  localparam int FB_PRE_TIMEOUT  = 5;
  localparam int FB_MOT_LT_BATT  = 6;

  typedef enum logic [3:0] {
    ST_WAIT = 4'b0001,
    ST_INIT = 4'b0010,
    ST_PRE  = 4'b0100,
    ST_DONE = 4'b1000
  } hps_state_t;

  typedef struct packed {
    logic [TICK_W-1:0]  timeout_ticks;
    logic [UV_W-1:0]    undervoltage_mv;
    logic [RATIO_W-1:0] volt_scale;
    logic [RATIO_W-1:0] done_ratio;
    logic [RATIO_W-1:0] hold_ratio;
  } hps_cfg_t;

  typedef struct packed {
    logic ignition;
    logic hv_plus_closed;
    logic hv_minus_closed;
    logic prot_fault;
    logic adc_ok;
    logic motor_sense_closed;
    logic precharge_sense_closed;
    logic motor_ack_ok;
    logic precharge_ack_ok;
  } hps_flags_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic               motor_contactor_cmd;
    logic               precharge_contactor_cmd;
    logic [FAULT_W-1:0] fault_mask;
    logic               complete_led;
  } hps_result_t;

endpackage

>>> rtl/core/hps_cfg_regs.sv
module hps_cfg_regs (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [hps_pkg::ADDR_W-1:0] paddr,
  input  logic [hps_pkg::DATA_W-1:0] pwdata,
  output logic [hps_pkg::DATA_W-1:0] prdata,
  output hps_pkg::hps_cfg_t        cfg
);
  import hps_pkg::*;

  hps_cfg_t         cfg_r;
  hps_cfg_t         cfg_nxt;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx   = paddr[ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_TIMEOUT:     cfg_nxt.timeout_ticks   = pwdata[TICK_W-1:0];
        REG_UNDERVOLT:   cfg_nxt.undervoltage_mv = pwdata[UV_W-1:0];
        REG_RATIO_SCALE: cfg_nxt.volt_scale      = pwdata[RATIO_W-1:0];
        REG_DONE_RATIO:  cfg_nxt.done_ratio      = pwdata[RATIO_W-1:0];
        REG_HOLD_RATIO:  cfg_nxt.hold_ratio      = pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks   <= RST_TIMEOUT;
      cfg_r.undervoltage_mv <= RST_UNDERVOLT;
      cfg_r.volt_scale      <= RST_RATIO_SCALE;
      cfg_r.done_ratio      <= RST_DONE_RATIO;
      cfg_r.hold_ratio      <= RST_HOLD_RATIO;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_TIMEOUT:     prdata = DATA_W'(cfg_r.timeout_ticks);
      REG_UNDERVOLT:   prdata = DATA_W'(cfg_r.undervoltage_mv);
      REG_RATIO_SCALE: prdata = DATA_W'(cfg_r.volt_scale);
      REG_DONE_RATIO:  prdata = DATA_W'(cfg_r.done_ratio);
      REG_HOLD_RATIO:  prdata = DATA_W'(cfg_r.hold_ratio);
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/hps_tick_core.sv
module hps_tick_core #(
  parameter int VOLTAGE_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  hps_pkg::hps_cfg_t       cfg,
  input  hps_pkg::hps_flags_t     flags,
  input  logic [VOLTAGE_BITS-1:0] battery_mv,
  input  logic [VOLTAGE_BITS-1:0] motor_mv,
  output hps_pkg::hps_result_t    result
);
  import hps_pkg::*;

  localparam int PROD_W = VOLTAGE_BITS + RATIO_W;
  localparam int CMP_W  = (VOLTAGE_BITS > UV_W) ? VOLTAGE_BITS : UV_W;

  hps_state_t          state_r, state_nxt;
  logic                prev_ign_r, prev_ign_nxt;
  logic [TICK_W-1:0]   elapsed_r, elapsed_nxt;
  logic                mcmd_r, mcmd_nxt;
  logic                pcmd_r, pcmd_nxt;

  logic [PROD_W-1:0]   motor_prod;
  logic [PROD_W-1:0]   batt_prod;
  logic [RATIO_W-1:0]  batt_ratio;
  logic [TICK_W-1:0]   elapsed_inc;
  logic [FAULT_W-1:0]  faults;
  logic [FAULT_W-1:0]  chk_faults;
  logic                rise, fall;

  // Completion ratio while precharging, hold ratio once complete
  assign batt_ratio = (state_r == ST_PRE) ? cfg.done_ratio : cfg.hold_ratio;
  assign motor_prod = PROD_W'(motor_mv) * PROD_W'(cfg.volt_scale);
  assign batt_prod  = PROD_W'(battery_mv) * PROD_W'(batt_ratio);

  assign elapsed_inc = (elapsed_r == {TICK_W{1'b1}}) ? elapsed_r : elapsed_r + 1'b1;

  assign rise = flags.ignition && !prev_ign_r;
  assign fall = !flags.ignition && prev_ign_r;

  always_comb begin
    chk_faults = '0;
    chk_faults[FB_UNDERVOLT]    = CMP_W'(battery_mv) < CMP_W'(cfg.undervoltage_mv);
    chk_faults[FB_MOT_MISMATCH] = flags.motor_sense_closed != mcmd_r;
    chk_faults[FB_PRE_MISMATCH] = flags.precharge_sense_closed != pcmd_r;
  end

  always_comb begin
    state_nxt    = state_r;
    elapsed_nxt  = elapsed_r;
    mcmd_nxt     = mcmd_r;
    pcmd_nxt     = pcmd_r;
    prev_ign_nxt = flags.ignition;
    faults       = '0;
    faults[FB_PRE_SENSE_TO] = !flags.adc_ok;

    if (rise) begin
      state_nxt = ST_INIT;
    end else if (fall) begin
      pcmd_nxt  = 1'b0;
      mcmd_nxt  = 1'b0;
      state_nxt = ST_WAIT;
      if (!flags.precharge_ack_ok) faults[FB_PRE_SENSE_TO] = 1'b1;
      if (!flags.motor_ack_ok) faults[FB_MOT_SENSE_TO] = 1'b1;
    end

    unique case (state_nxt)
      ST_WAIT: ;
      ST_INIT: begin
        if (flags.hv_plus_closed && flags.hv_minus_closed && !flags.prot_fault) begin
          mcmd_nxt    = 1'b1;
          state_nxt   = ST_PRE;
          elapsed_nxt = '0;
          if (!flags.motor_ack_ok) faults[FB_MOT_SENSE_TO] = 1'b1;
        end
      end
      ST_PRE: begin
        faults      = faults | chk_faults;
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc > cfg.timeout_ticks) begin
          if (motor_prod >= batt_prod) begin
            pcmd_nxt  = 1'b1;
            state_nxt = ST_DONE;
            if (!flags.precharge_ack_ok) faults[FB_MOT_SENSE_TO] = 1'b1;
          end else begin
            faults[FB_PRE_TIMEOUT] = 1'b1;
          end
        end
      end
      ST_DONE: begin
        faults = faults | chk_faults;
        if (motor_prod < batt_prod) faults[FB_MOT_LT_BATT] = 1'b1;
      end
      default: state_nxt = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_WAIT;
      prev_ign_r <= 1'b0;
      elapsed_r  <= '0;
      mcmd_r     <= 1'b0;
      pcmd_r     <= 1'b0;
    end else if (step) begin
      state_r    <= state_nxt;
      prev_ign_r <= prev_ign_nxt;
      elapsed_r  <= elapsed_nxt;
      mcmd_r     <= mcmd_nxt;
      pcmd_r     <= pcmd_nxt;
    end
  end

  always_comb begin
    unique case (state_nxt)
      ST_WAIT: result.phase = PH_WAIT;
      ST_INIT: result.phase = PH_INIT;
      ST_PRE:  result.phase = PH_PRE;
      ST_DONE: result.phase = PH_DONE;
      default: result.phase = PH_WAIT;
    endcase
    result.motor_contactor_cmd     = mcmd_nxt;
    result.precharge_contactor_cmd = pcmd_nxt;
    result.fault_mask              = faults;
    result.complete_led            = (state_nxt == ST_DONE);
  end

endmodule

>>> rtl/core/hv_precharge_sequencer.sv
// HV precharge sequencer: each item is one control tick (ignition, pack status, battery and
// motor bus voltages, contactor sense lines and command acknowledgements) and yields exactly
// one result item holding the phase, both contactor commands, the per-tick fault mask and the
// complete indicator. Items flow through an input register and a result register with the
// whole tick evaluated in a single pass between them, so the block takes one item per clock
// cycle while the result register is not stalled; each result is presented on the output once
// its item has passed the input register and then the result register. The sequencer state is
// updated as an item leaves the input register, so the next item sees it straight away. A
// stalled result register holds its item and back-pressures the input side only once the
// input register is also full. Configuration sits on an APB-style port at byte addresses 0x0
// (timeout ticks), 0x4 (undervoltage mV), 0x8 (ratio scale), 0xC (done ratio) and 0x10 (hold
// ratio); write it only while no item is in flight. Reset is synchronous, active low.
module hv_precharge_sequencer #(
  parameter int VOLTAGE_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,

  // Tick input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_ignition,
  input  logic                       in_hv_plus_closed,
  input  logic                       in_hv_minus_closed,
  input  logic                       in_prot_fault,
  input  logic                       in_adc_ok,
  input  logic [VOLTAGE_BITS-1:0]    in_battery_mv,
  input  logic [VOLTAGE_BITS-1:0]    in_motor_mv,
  input  logic                       in_motor_sense_closed,
  input  logic                       in_precharge_sense_closed,
  input  logic                       in_motor_ack_ok,
  input  logic                       in_precharge_ack_ok,

  // Result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_phase,
  output logic                       out_motor_contactor_cmd,
  output logic                       out_precharge_contactor_cmd,
  output logic [hps_pkg::FAULT_W-1:0] out_fault_mask,
  output logic                       out_complete_led,

  // Configuration port
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [hps_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [hps_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [hps_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import hps_pkg::*;

  hps_cfg_t                cfg;

  // Input register
  logic                    s1_vld_r, s1_vld_nxt;
  hps_flags_t              s1_flags_r;
  logic [VOLTAGE_BITS-1:0] s1_batt_r;
  logic [VOLTAGE_BITS-1:0] s1_motor_r;

  // Result register
  logic                    out_vld_r, out_vld_nxt;
  hps_result_t             out_res_r;
  hps_result_t             tick_res;

  logic                    in_take;
  logic                    advance;

  assign cfg_pready = 1'b1;

  hps_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // Advance the held item into the result register whenever that register is free or draining
  assign advance  = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || advance;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_take) begin
      s1_vld_nxt = 1'b1;
    end else if (advance) begin
      s1_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Capture the payload of an accepted item
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_flags_r.ignition               <= in_ignition;
      s1_flags_r.hv_plus_closed         <= in_hv_plus_closed;
      s1_flags_r.hv_minus_closed        <= in_hv_minus_closed;
      s1_flags_r.prot_fault             <= in_prot_fault;
      s1_flags_r.adc_ok                 <= in_adc_ok;
      s1_flags_r.motor_sense_closed     <= in_motor_sense_closed;
      s1_flags_r.precharge_sense_closed <= in_precharge_sense_closed;
      s1_flags_r.motor_ack_ok           <= in_motor_ack_ok;
      s1_flags_r.precharge_ack_ok       <= in_precharge_ack_ok;
      s1_batt_r                         <= in_battery_mv;
      s1_motor_r                        <= in_motor_mv;
    end
  end

  // Sequencer state commits on the same edge that the result is captured
  hps_tick_core #(
    .VOLTAGE_BITS (VOLTAGE_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .cfg        (cfg),
    .flags      (s1_flags_r),
    .battery_mv (s1_batt_r),
    .motor_mv   (s1_motor_r),
    .result     (tick_res)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= tick_res;
    end
  end

  assign out_valid                   = out_vld_r;
  assign out_phase                   = out_res_r.phase;
  assign out_motor_contactor_cmd     = out_res_r.motor_contactor_cmd;
  assign out_precharge_contactor_cmd = out_res_r.precharge_contactor_cmd;
  assign out_fault_mask              = out_res_r.fault_mask;
  assign out_complete_led            = out_res_r.complete_led;

endmodule

>>> rtl/core/hps_checker.sv
module hps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_phase,
  input logic       out_motor_contactor_cmd,
  input logic       out_precharge_contactor_cmd,
  input logic       out_complete_led
);
  import hps_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phase)
      && $stable(out_motor_contactor_cmd) && $stable(out_precharge_contactor_cmd))
    else $error("result changed while stalled");

  a_led_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_complete_led == (out_phase == PH_DONE)))
    else $error("complete indicator disagrees with phase");

  // Waiting or initial: both contactors open
  a_open_early: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_phase == PH_WAIT || out_phase == PH_INIT)
      |-> !out_motor_contactor_cmd && !out_precharge_contactor_cmd)
    else $error("contactor commanded closed before precharge");

  // Precharging: motor closed, precharge open; complete: both closed
  a_cmd_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_phase == PH_PRE || out_phase == PH_DONE)
      |-> out_motor_contactor_cmd
        && (out_precharge_contactor_cmd == (out_phase == PH_DONE)))
    else $error("contactor commands out of sequence");

endmodule

bind hv_precharge_sequencer hps_checker u_hps_checker (.*);

>>> tb/hps_tb_pkg.sv
package hps_tb_pkg;
  import hps_pkg::*;

  localparam int VBITS = 20;
  localparam logic [VBITS-1:0] MAX_MV = '1;

  typedef struct packed {
    logic             ignition;
    logic             hv_plus_closed;
    logic             hv_minus_closed;
    logic             prot_fault;
    logic             adc_ok;
    logic [VBITS-1:0] battery_mv;
    logic [VBITS-1:0] motor_mv;
    logic             motor_sense_closed;
    logic             precharge_sense_closed;
    logic             motor_ack_ok;
    logic             precharge_ack_ok;
  } tick_t;

  // Tracks the sequencer's state tick by tick and holds the status it should report next.
  class precharge_tracker;
    logic [TICK_W-1:0]  timeout_ticks;
    logic [UV_W-1:0]    undervoltage_mv;
    logic [RATIO_W-1:0] volt_scale;
    logic [RATIO_W-1:0] done_ratio;
    logic [RATIO_W-1:0] hold_ratio;

    logic [1:0]        phase;
    logic              prev_ign;
    logic [TICK_W-1:0] elapsed;
    logic              motor_cmd;
    logic              pre_cmd;

    hps_result_t pending_status[$];
    int          errors;
    int          results_seen;

    function new();
      timeout_ticks   = RST_TIMEOUT;
      undervoltage_mv = RST_UNDERVOLT;
      volt_scale      = RST_RATIO_SCALE;
      done_ratio      = RST_DONE_RATIO;
      hold_ratio      = RST_HOLD_RATIO;
      phase           = PH_WAIT;
      prev_ign        = 1'b0;
      elapsed         = '0;
      motor_cmd       = 1'b0;
      pre_cmd         = 1'b0;
      errors          = 0;
      results_seen    = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_TIMEOUT:     timeout_ticks   = val[TICK_W-1:0];
        REG_UNDERVOLT:   undervoltage_mv = val[UV_W-1:0];
        REG_RATIO_SCALE: volt_scale      = val[RATIO_W-1:0];
        REG_DONE_RATIO:  done_ratio      = val[RATIO_W-1:0];
        REG_HOLD_RATIO:  hold_ratio      = val[RATIO_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] reg_value(logic [IDX_W-1:0] idx);
      case (idx)
        REG_TIMEOUT:     return DATA_W'(timeout_ticks);
        REG_UNDERVOLT:   return DATA_W'(undervoltage_mv);
        REG_RATIO_SCALE: return DATA_W'(volt_scale);
        REG_DONE_RATIO:  return DATA_W'(done_ratio);
        default:         return DATA_W'(hold_ratio);
      endcase
    endfunction

    // Commands are compared as they stand before any precharge close in this tick.
    function logic [FAULT_W-1:0] sense_faults(tick_t t);
      logic [FAULT_W-1:0] f;
      f = '0;
      if (t.battery_mv < undervoltage_mv)        f[FB_UNDERVOLT]    = 1'b1;
      if (t.motor_sense_closed != motor_cmd)     f[FB_MOT_MISMATCH] = 1'b1;
      if (t.precharge_sense_closed != pre_cmd)   f[FB_PRE_MISMATCH] = 1'b1;
      return f;
    endfunction

    function void accept_tick(tick_t t);
      logic [FAULT_W-1:0] f;
      longint unsigned    motor_prod;
      longint unsigned    done_prod;
      longint unsigned    hold_prod;
      hps_result_t        st;
      f          = '0;
      motor_prod = 64'(t.motor_mv) * 64'(volt_scale);
      done_prod  = 64'(t.battery_mv) * 64'(done_ratio);
      hold_prod  = 64'(t.battery_mv) * 64'(hold_ratio);

      if (!t.adc_ok) f[FB_PRE_SENSE_TO] = 1'b1;

      if (t.ignition && !prev_ign) begin
        phase = PH_INIT;
      end else if (!t.ignition && prev_ign) begin
        pre_cmd = 1'b0;
        if (!t.precharge_ack_ok) f[FB_PRE_SENSE_TO] = 1'b1;
        motor_cmd = 1'b0;
        if (!t.motor_ack_ok) f[FB_MOT_SENSE_TO] = 1'b1;
        phase = PH_WAIT;
      end
      prev_ign = t.ignition;

      case (phase)
        PH_INIT: begin
          if (t.hv_plus_closed && t.hv_minus_closed && !t.prot_fault) begin
            motor_cmd = 1'b1;
            if (!t.motor_ack_ok) f[FB_MOT_SENSE_TO] = 1'b1;
            phase   = PH_PRE;
            elapsed = '0;
          end
        end
        PH_PRE: begin
          f |= sense_faults(t);
          if (elapsed != '1) elapsed++;
          if (elapsed > timeout_ticks) begin
            if (motor_prod >= done_prod) begin
              pre_cmd = 1'b1;
              if (!t.precharge_ack_ok) f[FB_MOT_SENSE_TO] = 1'b1;
              phase = PH_DONE;
            end else begin
              f[FB_PRE_TIMEOUT] = 1'b1;
            end
          end
        end
        PH_DONE: begin
          f |= sense_faults(t);
          if (motor_prod < hold_prod) f[FB_MOT_LT_BATT] = 1'b1;
        end
        default: ;
      endcase

      st.phase                   = phase;
      st.motor_contactor_cmd     = motor_cmd;
      st.precharge_contactor_cmd = pre_cmd;
      st.fault_mask              = f;
      st.complete_led            = (phase == PH_DONE);
      pending_status.push_back(st);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("ERROR: status %0d: %s", results_seen, msg);
    endtask

    task check_status(hps_result_t got);
      hps_result_t want;
      if (pending_status.size() == 0) begin
        report_mismatch("status item with nothing outstanding");
      end else begin
        want = pending_status.pop_front();
        if (got.phase !== want.phase)
          report_mismatch($sformatf("phase %0d, want %0d", got.phase, want.phase));
        if (got.motor_contactor_cmd !== want.motor_contactor_cmd)
          report_mismatch($sformatf("motor cmd %b, want %b",
                                    got.motor_contactor_cmd, want.motor_contactor_cmd));
        if (got.precharge_contactor_cmd !== want.precharge_contactor_cmd)
          report_mismatch($sformatf("precharge cmd %b, want %b",
                                    got.precharge_contactor_cmd,
                                    want.precharge_contactor_cmd));
        if (got.fault_mask !== want.fault_mask)
          report_mismatch($sformatf("fault mask %b, want %b",
                                    got.fault_mask, want.fault_mask));
        if (got.complete_led !== want.complete_led)
          report_mismatch($sformatf("complete led %b, want %b",
                                    got.complete_led, want.complete_led));
      end
      results_seen++;
    endtask
  endclass

endpackage

>>> tb/tb_top.sv
module tb_top;
  import hps_pkg::*;
  import hps_tb_pkg::*;

  // Generous ceiling on the length of the whole run.
  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_WAIT  = 4;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_ignition = 1'b0;
  logic             in_hv_plus_closed = 1'b0;
  logic             in_hv_minus_closed = 1'b0;
  logic             in_prot_fault = 1'b0;
  logic             in_adc_ok = 1'b0;
  logic [VBITS-1:0] in_battery_mv = '0;
  logic [VBITS-1:0] in_motor_mv = '0;
  logic             in_motor_sense_closed = 1'b0;
  logic             in_precharge_sense_closed = 1'b0;
  logic             in_motor_ack_ok = 1'b0;
  logic             in_precharge_ack_ok = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_phase;
  logic               out_motor_contactor_cmd;
  logic               out_precharge_contactor_cmd;
  logic [FAULT_W-1:0] out_fault_mask;
  logic               out_complete_led;

  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  precharge_tracker tracker;
  int               send_gap_pct = 0;
  int               recv_stall_pct = 0;
  int               random_sent;
  int               cycle_count = 0;

  hv_precharge_sequencer #(.VOLTAGE_BITS(VBITS)) u_top (
    .clk                         (clk),
    .rst_n                       (rst_n),
    .in_valid                    (in_valid),
    .in_ready                    (in_ready),
    .in_ignition                 (in_ignition),
    .in_hv_plus_closed           (in_hv_plus_closed),
    .in_hv_minus_closed          (in_hv_minus_closed),
    .in_prot_fault               (in_prot_fault),
    .in_adc_ok                   (in_adc_ok),
    .in_battery_mv               (in_battery_mv),
    .in_motor_mv                 (in_motor_mv),
    .in_motor_sense_closed       (in_motor_sense_closed),
    .in_precharge_sense_closed   (in_precharge_sense_closed),
    .in_motor_ack_ok             (in_motor_ack_ok),
    .in_precharge_ack_ok         (in_precharge_ack_ok),
    .out_valid                   (out_valid),
    .out_ready                   (out_ready),
    .out_phase                   (out_phase),
    .out_motor_contactor_cmd     (out_motor_contactor_cmd),
    .out_precharge_contactor_cmd (out_precharge_contactor_cmd),
    .out_fault_mask              (out_fault_mask),
    .out_complete_led            (out_complete_led),
    .cfg_psel                    (cfg_psel),
    .cfg_penable                 (cfg_penable),
    .cfg_pwrite                  (cfg_pwrite),
    .cfg_paddr                   (cfg_paddr),
    .cfg_pwdata                  (cfg_pwdata),
    .cfg_prdata                  (cfg_prdata),
    .cfg_pready                  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: a hung handshake must not stall the run for ever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check each status item taken at this edge, then pick next
  // cycle's ready. Values read here are the ones the block saw at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_status({out_phase, out_motor_contactor_cmd, out_precharge_contactor_cmd,
                            out_fault_mask, out_complete_led});
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_gap_pct = 50; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 50; end
      default:       begin send_gap_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  // One APB transfer, setup then access. Leave psel/penable as they are at the
  // end so that back-to-back transfers never assign a signal twice in one step.
  task automatic apb_xfer(input bit wr, input logic [IDX_W-1:0] idx,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rdata = cfg_prdata;
  endtask

  // Write all five registers, read them back, then release the bus.
  task automatic program_cfg(input logic [DATA_W-1:0] timeout, input logic [DATA_W-1:0] uv,
                             input logic [DATA_W-1:0] scale, input logic [DATA_W-1:0] done,
                             input logic [DATA_W-1:0] hold);
    logic [DATA_W-1:0] vals [5];
    logic [IDX_W-1:0]  idxs [5];
    logic [DATA_W-1:0] rd;
    vals = '{timeout, uv, scale, done, hold};
    idxs = '{REG_TIMEOUT, REG_UNDERVOLT, REG_RATIO_SCALE, REG_DONE_RATIO, REG_HOLD_RATIO};
    for (int i = 0; i < 5; i++) begin
      apb_xfer(1'b1, idxs[i], vals[i], rd);
      tracker.set_reg(idxs[i], vals[i]);
    end
    for (int i = 0; i < 5; i++) begin
      apb_xfer(1'b0, idxs[i], '0, rd);
      if (rd !== tracker.reg_value(idxs[i]))
        tracker.report_mismatch($sformatf("register %0d reads %0h, want %0h",
                                          idxs[i], rd, tracker.reg_value(idxs[i])));
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Present one tick, after an optional idle gap, and hold it until taken.
  task automatic send_tick(tick_t t);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid                  <= 1'b1;
    in_ignition               <= t.ignition;
    in_hv_plus_closed         <= t.hv_plus_closed;
    in_hv_minus_closed        <= t.hv_minus_closed;
    in_prot_fault             <= t.prot_fault;
    in_adc_ok                 <= t.adc_ok;
    in_battery_mv             <= t.battery_mv;
    in_motor_mv               <= t.motor_mv;
    in_motor_sense_closed     <= t.motor_sense_closed;
    in_precharge_sense_closed <= t.precharge_sense_closed;
    in_motor_ack_ok           <= t.motor_ack_ok;
    in_precharge_ack_ok       <= t.precharge_ack_ok;
    do @(posedge clk); while (!in_ready);
    tracker.accept_tick(t);
  endtask

  // Drop valid, wait for every outstanding status item, then let the pipe settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (tracker.pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic tick_t mk(bit ign, bit plus, bit minus, bit bps, bit adc,
                               logic [VBITS-1:0] batt, logic [VBITS-1:0] motor,
                               bit msense, bit psense, bit mack, bit pack);
    tick_t t;
    t = '{ign, plus, minus, bps, adc, batt, motor, msense, psense, mack, pack};
    return t;
  endfunction

  function automatic logic [VBITS-1:0] clamp_mv(longint v);
    if (v < 0) return '0;
    if (v > longint'(MAX_MV)) return MAX_MV;
    return v[VBITS-1:0];
  endfunction

  // Build a tick. Well-formed ticks keep sense lines mostly in step with the
  // commands and usually put the motor voltage close to the done or hold threshold.
  function automatic tick_t make_tick(bit ign, bit ready, bit noisy);
    tick_t           t;
    longint unsigned thr;
    int              pick;
    t.ignition               = $urandom_range(1);
    t.hv_plus_closed         = $urandom_range(1);
    t.hv_minus_closed        = $urandom_range(1);
    t.prot_fault             = $urandom_range(1);
    t.adc_ok                 = $urandom_range(1);
    t.battery_mv             = VBITS'($urandom);
    t.motor_mv               = VBITS'($urandom);
    t.motor_sense_closed     = $urandom_range(1);
    t.precharge_sense_closed = $urandom_range(1);
    t.motor_ack_ok           = $urandom_range(1);
    t.precharge_ack_ok       = $urandom_range(1);
    if (noisy) return t;

    t.ignition = ign;
    if (ready) begin
      t.hv_plus_closed  = 1'b1;
      t.hv_minus_closed = 1'b1;
      t.prot_fault      = 1'b0;
    end else begin
      while (t.hv_plus_closed && t.hv_minus_closed && !t.prot_fault) begin
        t.hv_plus_closed  = $urandom_range(1);
        t.hv_minus_closed = $urandom_range(1);
        t.prot_fault      = $urandom_range(1);
      end
    end
    t.adc_ok = ($urandom_range(99) < 92);

    pick = $urandom_range(9);
    if (pick == 0)      t.battery_mv = '0;
    else if (pick == 1) t.battery_mv = MAX_MV;
    else if (pick <= 3)
      t.battery_mv = clamp_mv(longint'(tracker.undervoltage_mv) + $urandom_range(6) - 3);

    pick = $urandom_range(9);
    if (pick <= 7) begin
      thr = 64'(t.battery_mv) * ((pick <= 4) ? tracker.done_ratio : tracker.hold_ratio);
      thr = (thr + tracker.volt_scale - 1) / tracker.volt_scale;
      t.motor_mv = clamp_mv(longint'(thr) + $urandom_range(4) - 2);
    end else if (pick == 9) begin
      t.motor_mv = MAX_MV;
    end

    t.motor_sense_closed     = tracker.motor_cmd ^ ($urandom_range(99) < 8);
    t.precharge_sense_closed = tracker.pre_cmd ^ ($urandom_range(99) < 8);
    t.motor_ack_ok           = ($urandom_range(99) < 90);
    t.precharge_ack_ok       = ($urandom_range(99) < 90);
    return t;
  endfunction

  // Mostly well-formed content, with some ticks replaced by noise.
  task automatic send_mixed(bit ign, bit ready);
    send_tick(make_tick(ign, ready, $urandom_range(99) < 12));
    random_sent++;
  endtask

  // Whole ignition cycles: off, a few not-ready ticks, pack ready, precharge
  // long enough to be judged (where the timeout allows), then a spell complete.
  task automatic run_random(int n_items);
    int len;
    random_sent = 0;
    while (random_sent < n_items) begin
      len = $urandom_range(3, 1);
      repeat (len) send_mixed(1'b0, $urandom_range(1));
      len = $urandom_range(2);
      repeat (len) send_mixed(1'b1, 1'b0);
      send_mixed(1'b1, 1'b1);
      if (tracker.timeout_ticks <= 8)
        len = tracker.timeout_ticks + 1 + $urandom_range(2);
      else if (tracker.timeout_ticks <= 120 && $urandom_range(9) == 0)
        len = tracker.timeout_ticks + 2;
      else
        len = $urandom_range(8, 1);
      repeat (len) send_mixed(1'b1, $urandom_range(1));
      len = $urandom_range(6);
      repeat (len) send_mixed(1'b1, $urandom_range(1));
    end
  endtask

  // Timeout is two ticks here, so the third precharge tick is judged.
  task automatic run_directed;
    // waiting: late conversion, then every flag and both voltages at full scale
    send_tick(mk(0, 0, 0, 0, 0, '0, '0, 0, 0, 0, 0));
    send_tick(mk(0, 1, 1, 1, 1, MAX_MV, MAX_MV, 1, 1, 1, 1));
    // ignition on, pack not ready for each of its three reasons
    send_tick(mk(1, 0, 1, 0, 1, 20'd100000, '0, 0, 0, 1, 1));
    send_tick(mk(1, 1, 0, 0, 1, 20'd100000, '0, 0, 0, 1, 1));
    send_tick(mk(1, 1, 1, 1, 1, 20'd100000, '0, 0, 0, 1, 1));
    // pack ready, motor close not acknowledged
    send_tick(mk(1, 1, 1, 0, 1, 20'd100000, '0, 0, 0, 0, 1));
    // undervoltage with both sense lines wrong, then a tick with a late conversion
    send_tick(mk(1, 1, 1, 0, 1, 20'd1000, '0, 0, 1, 1, 1));
    send_tick(mk(1, 0, 0, 1, 0, 20'd100000, '0, 1, 0, 1, 1));
    // timeout expires with the bus still low
    send_tick(mk(1, 1, 1, 0, 1, 20'd100000, '0, 1, 0, 1, 1));
    // ratio exactly at done threshold: close precharge, ack lost
    send_tick(mk(1, 1, 1, 0, 1, 20'd100000, 20'd90000, 1, 0, 1, 0));
    // hold ratio just missed, then exactly met
    send_tick(mk(1, 1, 1, 0, 1, 20'd100000, 20'd79999, 1, 1, 1, 1));
    send_tick(mk(1, 1, 1, 0, 1, 20'd100000, 20'd80000, 1, 1, 1, 1));
    send_tick(mk(1, 1, 1, 0, 0, MAX_MV, MAX_MV, 0, 0, 1, 1));
    // ignition off with both open commands unacknowledged
    send_tick(mk(0, 1, 1, 0, 1, 20'd100000, 20'd80000, 1, 1, 0, 0));
    // ignition back on with a dead bus: zero against zero completes
    send_tick(mk(1, 1, 1, 0, 1, '0, '0, 0, 0, 1, 1));
    repeat (3) send_tick(mk(1, 1, 1, 0, 1, '0, '0, 1, 0, 1, 1));
    send_tick(mk(1, 1, 1, 0, 1, MAX_MV, '0, 1, 1, 1, 1));
    send_tick(mk(1, 1, 1, 0, 1, '0, MAX_MV, 1, 1, 1, 1));
    send_tick(mk(0, 0, 0, 0, 1, 20'd100000, '0, 0, 0, 1, 1));
    // one millivolt short of the done threshold: timeout fault
    send_tick(mk(1, 1, 1, 0, 1, 20'd100000, 20'd89999, 0, 0, 1, 1));
    repeat (3) send_tick(mk(1, 1, 1, 0, 1, 20'd100000, 20'd89999, 1, 0, 1, 1));
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases on a short timeout
    program_cfg(2, 80000, 100, 90, 80);
    set_idle(IDLE_NONE);
    run_directed();
    drain();

    // Everything at its floor: instant timeout, no undervoltage, unit scale
    program_cfg(0, 0, 1, 0, 0);
    set_idle(IDLE_SENDER);
    run_random(200);
    drain();

    // Everything at its ceiling: the timeout never expires
    program_cfg(16'hFFFF, 20'hFFFFF, 255, 255, 255);
    set_idle(IDLE_RECEIVER);
    run_random(250);
    drain();

    // Shorten the timeout while possibly still precharging: a running count
    // already past it must expire straight away
    program_cfg(3, $urandom_range(20'hFFFFF), 128, $urandom_range(255), $urandom_range(255));
    set_idle(IDLE_BOTH);
    repeat (3) send_tick(make_tick(1'b1, 1'b1, 1'b0));
    run_random(200);
    drain();

    program_cfg($urandom_range(6), $urandom_range(20'hFFFFF), $urandom_range(255, 1),
                $urandom_range(255), $urandom_range(255));
    set_idle(IDLE_NONE);
    run_random(200);
    drain();

    // Back to the power-on values
    program_cfg(RST_TIMEOUT, RST_UNDERVOLT, RST_RATIO_SCALE, RST_DONE_RATIO, RST_HOLD_RATIO);
    set_idle(IDLE_SENDER);
    run_random(150);
    drain();

    program_cfg($urandom_range(12), $urandom_range(20'hFFFFF), $urandom_range(255, 1),
                $urandom_range(255), $urandom_range(255));
    set_idle(IDLE_RECEIVER);
    run_random(200);
    drain();

    program_cfg($urandom_range(4), $urandom_range(150000), $urandom_range(255, 1),
                $urandom_range(255), $urandom_range(255));
    set_idle(IDLE_BOTH);
    run_random(200);
    drain();

    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/hps_pkg.sv
rtl/core/hps_cfg_regs.sv
rtl/core/hps_tick_core.sv
rtl/core/hv_precharge_sequencer.sv
rtl/core/hps_checker.sv
tb/hps_tb_pkg.sv
tb/tb_top.sv
